// File: src/llr_pkg.sv
// Shared constants, types and codes of the looped linear resampler.
package llr_pkg;

    localparam int ADDR_BITS   = 16;
    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = 16;

    localparam int PHASE_BITS  = ADDR_BITS + FRAC_BITS;
    localparam int STEP_BITS   = 8 + FRAC_BITS;
    localparam int LOOP_BITS   = 16;
    localparam int COUNT_BITS  = ADDR_BITS + 1;
    localparam int IN_ADDR_BITS = 16;
    localparam int CFG_DATA_BITS = 24;
    localparam int CFG_INDEX_BITS = 2;
    localparam int STORE_DEPTH = 1 << ADDR_BITS;
    localparam int DIV_CNT_BITS = $clog2(ADDR_BITS);
    localparam int PROD_BITS   = FRAC_BITS + SAMPLE_BITS + 2;

    localparam logic [STEP_BITS-1:0]  SPEED_STEP_RESET  = STEP_BITS'(1 << FRAC_BITS);
    localparam logic [LOOP_BITS-1:0]  LOOP_START_RESET  = LOOP_BITS'(1);
    localparam logic [LOOP_BITS-1:0]  LOOP_FINISH_RESET = '0;
    localparam logic [COUNT_BITS-1:0] FRAME_COUNT_RESET = '0;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_SPEED_STEP  = 2'd0,
        REG_LOOP_START  = 2'd1,
        REG_LOOP_FINISH = 2'd2,
        REG_FRAME_COUNT = 2'd3
    } t_cfg_reg;

    typedef enum logic {
        FUNC_WRITE = 1'b0,
        FUNC_TICK  = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        SEL_WRITE,
        SEL_LOWER,
        SEL_UPPER
    } t_addr_sel;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_ZERO,
        S_MOD,
        S_FIX,
        S_RDA,
        S_RDB,
        S_DIFF,
        S_MUL,
        S_SUM
    } t_state;

    typedef struct packed {
        logic      ram_we;
        t_addr_sel addr_sel;
        logic      div_init;
        logic      div_step;
        logic      wrap_fix;
        logic      cap_lower;
        logic      cap_diff;
        logic      cap_prod;
        logic      load_zero;
        logic      load_result;
        logic      advance;
    } t_dp_cmd;

    typedef struct packed {
        logic reverse_end;
        logic wrap_need;
        logic div_last;
    } t_dp_status;

endpackage

// File: src/llr_if.sv
// Request channels of the looped linear resampler: items, results and register writes.
interface llr_item_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 func;
    logic [llr_pkg::IN_ADDR_BITS-1:0]     sample_addr;
    logic signed [llr_pkg::SAMPLE_BITS-1:0] sample_value;

    modport source (output valid, func, sample_addr, sample_value, input ready);
    modport sink   (input valid, func, sample_addr, sample_value, output ready);
endinterface

interface llr_result_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [llr_pkg::SAMPLE_BITS-1:0] interp_value;

    modport source (output valid, interp_value, input ready);
    modport sink   (input valid, interp_value, output ready);
endinterface

interface llr_cfg_if;
    logic                                  valid;
    logic                                  ready;
    logic [llr_pkg::CFG_INDEX_BITS-1:0]    reg_index;
    logic [llr_pkg::CFG_DATA_BITS-1:0]     wr_data;

    modport source (output valid, reg_index, wr_data, input ready);
    modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

// File: src/llr_ram.sv
// Generic single-port RAM with a registered read.
module llr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/llr_datapath.sv
// Datapath: registers, sample store, loop wrap remainder unit and interpolator.
module llr_datapath (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  llr_pkg::t_dp_cmd                      i_cmd,
    output llr_pkg::t_dp_status                   o_status,
    input  logic [llr_pkg::IN_ADDR_BITS-1:0]      i_wr_addr,
    input  logic signed [llr_pkg::SAMPLE_BITS-1:0] i_wr_value,
    input  logic                                  i_cfg_we,
    input  llr_pkg::t_cfg_reg                     i_cfg_index,
    input  logic [llr_pkg::CFG_DATA_BITS-1:0]     i_cfg_data,
    output logic signed [llr_pkg::SAMPLE_BITS-1:0] o_interp_value
);

    localparam int AB = llr_pkg::ADDR_BITS;
    localparam int SB = llr_pkg::SAMPLE_BITS;
    localparam int FB = llr_pkg::FRAC_BITS;
    localparam int PB = llr_pkg::PHASE_BITS;
    localparam int XB = llr_pkg::PROD_BITS;

    logic [llr_pkg::STEP_BITS-1:0]  r_speed_step;
    logic [llr_pkg::LOOP_BITS-1:0]  r_loop_start;
    logic [llr_pkg::LOOP_BITS-1:0]  r_loop_finish;
    logic [llr_pkg::COUNT_BITS-1:0] r_frame_count;

    logic [PB-1:0]                  r_phase, n_phase;
    logic [AB-1:0]                  r_rem, n_rem;
    logic [AB-1:0]                  r_dvd, n_dvd;
    logic [llr_pkg::DIV_CNT_BITS-1:0] r_cnt, n_cnt;
    logic signed [SB-1:0]           r_lower, n_lower;
    logic signed [SB:0]             r_diff, n_diff;
    logic signed [XB-1:0]           r_prod, n_prod;
    logic signed [SB-1:0]           r_out, n_out;

    logic [AB-1:0]   phase_int;
    logic [FB-1:0]   phase_frac;
    logic [AB:0]     frame_lo;
    logic [AB:0]     frame_hi;
    logic [AB-1:0]   start_a;
    logic [AB-1:0]   finish_a;
    logic [AB-1:0]   loop_len;
    logic [AB:0]     trial;
    logic [AB:0]     trial_sub;
    logic            lo_valid;
    logic            hi_valid;
    logic [AB-1:0]   ram_addr;
    logic [SB-1:0]   ram_rdata;
    logic signed [SB-1:0] upper;
    logic [PB:0]     phase_sum;
    logic signed [XB-1:0] rounded;
    logic signed [XB-1:0] scaled;
    logic signed [XB-1:0] result_wide;

    assign phase_int  = r_phase[PB-1:FB];
    assign phase_frac = r_phase[FB-1:0];
    assign frame_lo   = {1'b0, phase_int};
    assign frame_hi   = frame_lo + (AB+1)'(1);
    assign start_a    = AB'(r_loop_start);
    assign finish_a   = AB'(r_loop_finish);
    assign loop_len   = finish_a - start_a;
    assign lo_valid   = frame_lo < r_frame_count;
    assign hi_valid   = (frame_hi < r_frame_count) && !frame_hi[AB];

    assign trial     = {r_rem, r_dvd[AB-1]};
    assign trial_sub = trial - {1'b0, loop_len};

    assign o_status.reverse_end = (r_loop_start > r_loop_finish) && !lo_valid;
    assign o_status.wrap_need   = (r_loop_start < r_loop_finish) && (phase_int >= finish_a);
    assign o_status.div_last    = r_cnt == llr_pkg::DIV_CNT_BITS'(AB - 1);

    always_comb begin
        unique case (i_cmd.addr_sel)
            llr_pkg::SEL_LOWER: ram_addr = frame_lo[AB-1:0];
            llr_pkg::SEL_UPPER: ram_addr = frame_hi[AB-1:0];
            default:            ram_addr = AB'(i_wr_addr);
        endcase
    end

    llr_ram #(
        .WIDTH (SB),
        .DEPTH (llr_pkg::STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ram_we),
        .i_addr  (ram_addr),
        .i_wdata (i_wr_value),
        .o_rdata (ram_rdata)
    );

    assign upper       = hi_valid ? $signed(ram_rdata) : '0;
    assign phase_sum   = {1'b0, r_phase} + (PB+1)'(r_speed_step);
    assign rounded     = r_prod + XB'(1 << (FB - 1));
    assign scaled      = rounded >>> FB;
    assign result_wide = XB'(r_lower) + scaled;

    always_comb begin
        n_phase = r_phase;
        n_rem   = r_rem;
        n_dvd   = r_dvd;
        n_cnt   = r_cnt;
        n_lower = r_lower;
        n_diff  = r_diff;
        n_prod  = r_prod;
        n_out   = r_out;
        if (i_cmd.div_init) begin
            n_rem = '0;
            n_dvd = phase_int - start_a;
            n_cnt = '0;
        end
        if (i_cmd.div_step) begin
            n_rem = trial_sub[AB] ? trial[AB-1:0] : trial_sub[AB-1:0];
            n_dvd = {r_dvd[AB-2:0], 1'b0};
            n_cnt = r_cnt + llr_pkg::DIV_CNT_BITS'(1);
        end
        if (i_cmd.wrap_fix) begin
            n_phase = {start_a + r_rem, phase_frac};
        end
        if (i_cmd.cap_lower) begin
            n_lower = lo_valid ? $signed(ram_rdata) : '0;
        end
        if (i_cmd.cap_diff) begin
            n_diff = (SB+1)'(upper) - (SB+1)'(r_lower);
        end
        if (i_cmd.cap_prod) begin
            n_prod = XB'($signed({1'b0, phase_frac}) * r_diff);
        end
        if (i_cmd.load_zero) begin
            n_out = '0;
        end
        if (i_cmd.load_result) begin
            n_out = result_wide[SB-1:0];
        end
        if (i_cmd.advance) begin
            n_phase = phase_sum[PB] ? '1 : phase_sum[PB-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= '0;
            r_speed_step  <= llr_pkg::SPEED_STEP_RESET;
            r_loop_start  <= llr_pkg::LOOP_START_RESET;
            r_loop_finish <= llr_pkg::LOOP_FINISH_RESET;
            r_frame_count <= llr_pkg::FRAME_COUNT_RESET;
            r_cnt         <= '0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    llr_pkg::REG_SPEED_STEP:
                        r_speed_step <= i_cfg_data[llr_pkg::STEP_BITS-1:0];
                    llr_pkg::REG_LOOP_START:
                        r_loop_start <= i_cfg_data[llr_pkg::LOOP_BITS-1:0];
                    llr_pkg::REG_LOOP_FINISH:
                        r_loop_finish <= i_cfg_data[llr_pkg::LOOP_BITS-1:0];
                    llr_pkg::REG_FRAME_COUNT:
                        r_frame_count <= i_cfg_data[llr_pkg::COUNT_BITS-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem   <= n_rem;
        r_dvd   <= n_dvd;
        r_lower <= n_lower;
        r_diff  <= n_diff;
        r_prod  <= n_prod;
        r_out   <= n_out;
    end

    assign o_interp_value = r_out;

endmodule

// File: src/llr_ctrl.sv
// Controller: sequences writes and ticks and owns the result handshake.
module llr_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_func,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  llr_pkg::t_dp_status  i_status,
    output llr_pkg::t_dp_cmd     o_cmd
);

    llr_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;
    logic            out_free;
    logic            accept;

    assign out_free = !r_out_valid || i_out_ready;
    assign accept   = i_in_valid && (r_state == llr_pkg::S_IDLE);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            llr_pkg::S_IDLE: begin
                if (accept && (i_in_func == llr_pkg::FUNC_TICK)) begin
                    n_state = llr_pkg::S_CHECK;
                end
            end
            llr_pkg::S_CHECK: begin
                priority if (i_status.reverse_end) begin
                    n_state = llr_pkg::S_ZERO;
                end else if (i_status.wrap_need) begin
                    n_state = llr_pkg::S_MOD;
                end else begin
                    n_state = llr_pkg::S_RDA;
                end
            end
            llr_pkg::S_ZERO: begin
                if (out_free) begin
                    n_state = llr_pkg::S_IDLE;
                end
            end
            llr_pkg::S_MOD: begin
                if (i_status.div_last) begin
                    n_state = llr_pkg::S_FIX;
                end
            end
            llr_pkg::S_FIX:  n_state = llr_pkg::S_RDA;
            llr_pkg::S_RDA:  n_state = llr_pkg::S_RDB;
            llr_pkg::S_RDB:  n_state = llr_pkg::S_DIFF;
            llr_pkg::S_DIFF: n_state = llr_pkg::S_MUL;
            llr_pkg::S_MUL:  n_state = llr_pkg::S_SUM;
            llr_pkg::S_SUM: begin
                if (out_free) begin
                    n_state = llr_pkg::S_IDLE;
                end
            end
            default: n_state = llr_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_cmd.addr_sel = llr_pkg::SEL_WRITE;
        o_in_ready  = 1'b0;
        unique case (r_state)
            llr_pkg::S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.ram_we = accept && (i_in_func == llr_pkg::FUNC_WRITE);
            end
            llr_pkg::S_CHECK: begin
                o_cmd.div_init = !i_status.reverse_end && i_status.wrap_need;
            end
            llr_pkg::S_ZERO: begin
                o_cmd.load_zero = out_free;
                o_cmd.advance   = out_free;
            end
            llr_pkg::S_MOD: begin
                o_cmd.div_step = 1'b1;
            end
            llr_pkg::S_FIX: begin
                o_cmd.wrap_fix = 1'b1;
            end
            llr_pkg::S_RDA: begin
                o_cmd.addr_sel = llr_pkg::SEL_LOWER;
            end
            llr_pkg::S_RDB: begin
                o_cmd.addr_sel  = llr_pkg::SEL_UPPER;
                o_cmd.cap_lower = 1'b1;
            end
            llr_pkg::S_DIFF: begin
                o_cmd.cap_diff = 1'b1;
            end
            llr_pkg::S_MUL: begin
                o_cmd.cap_prod = 1'b1;
            end
            llr_pkg::S_SUM: begin
                o_cmd.load_result = out_free;
                o_cmd.advance     = out_free;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        priority if (o_cmd.load_zero || o_cmd.load_result) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= llr_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// File: src/looped_linear_resampler_unit.sv
// Top level of the looped linear resampler: controller, datapath and request channels.
// A sample write leaves the controller idle, so writes can be accepted on consecutive cycles.
// A tick runs through CHECK, RDA, RDB, DIFF, MUL and SUM, which loads its result; past the
// reverse end it goes to ZERO, and a wrap into the loop adds MOD (bit-serial remainder) and FIX.
// A new request is taken in the cycle after a tick's result is loaded into the output register.
// Synchronous active-low reset restores phase, registers and handshakes; the store keeps its data.
module looped_linear_resampler_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    llr_item_if.sink      i_item,
    llr_result_if.source  o_result,
    llr_cfg_if.sink       i_cfg
);

    llr_pkg::t_dp_cmd    cmd;
    llr_pkg::t_dp_status status;
    logic                in_ready;
    logic                cfg_we;

    assign i_cfg.ready = 1'b1;
    assign cfg_we      = i_cfg.valid;
    assign i_item.ready = in_ready;

    llr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .i_in_func   (i_item.func),
        .o_in_ready  (in_ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    llr_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_wr_addr      (i_item.sample_addr),
        .i_wr_value     (i_item.sample_value),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (llr_pkg::t_cfg_reg'(i_cfg.reg_index)),
        .i_cfg_data     (i_cfg.wr_data),
        .o_interp_value (o_result.interp_value)
    );

endmodule

// File: sim/llr_playback_monitor.sv
// Playback monitor: predicts each tick's interpolated sample and checks the result channel.
module llr_playback_monitor
    import llr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    llr_item_if   i_item,
    llr_result_if i_result,
    llr_cfg_if    i_cfg,
    output int    o_pending,
    output int    o_errors
);
    timeunit 1ns;
    timeprecision 1ps;

    logic signed [SAMPLE_BITS-1:0] pcm_mem [STORE_DEPTH];
    logic [PHASE_BITS-1:0]         pos;
    logic [STEP_BITS-1:0]          step_reg;
    logic [LOOP_BITS-1:0]          loop_lo;
    logic [LOOP_BITS-1:0]          loop_hi;
    logic [COUNT_BITS-1:0]         frames_valid;
    logic signed [SAMPLE_BITS-1:0] interp_due [$];
    int                            mismatches = 0;

    function automatic logic signed [SAMPLE_BITS-1:0] pcm_at(input logic [ADDR_BITS:0] frame);
        if (frame >= frames_valid || frame >= (ADDR_BITS + 1)'(STORE_DEPTH)) begin
            return '0;
        end
        return pcm_mem[frame[ADDR_BITS-1:0]];
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] resample_tick();
        logic [PHASE_BITS-1:0]         lo_fx;
        logic [PHASE_BITS-1:0]         span;
        logic [PHASE_BITS:0]           next_pos;
        logic [ADDR_BITS:0]            frame;
        longint                        frac;
        longint                        lower;
        longint                        upper;
        longint                        slope;
        logic signed [SAMPLE_BITS-1:0] value;
        lo_fx = PHASE_BITS'(loop_lo) << FRAC_BITS;
        span  = (PHASE_BITS'(loop_hi) << FRAC_BITS) - lo_fx;
        if (loop_lo > loop_hi && longint'(pos) >= (longint'(frames_valid) << FRAC_BITS)) begin
            value = '0;
        end else begin
            if (loop_lo < loop_hi && pos >= (PHASE_BITS'(loop_hi) << FRAC_BITS)) begin
                pos = lo_fx + (pos - lo_fx) % span;
            end
            frame = (ADDR_BITS + 1)'(pos >> FRAC_BITS);
            frac  = longint'(pos[FRAC_BITS-1:0]);
            lower = longint'(pcm_at(frame));
            upper = longint'(pcm_at(frame + 1'b1));
            slope = frac * (upper - lower) + (longint'(1) << (FRAC_BITS - 1));
            value = SAMPLE_BITS'(lower + (slope >>> FRAC_BITS));
        end
        next_pos = {1'b0, pos} + (PHASE_BITS + 1)'(step_reg);
        pos = next_pos[PHASE_BITS] ? '1 : next_pos[PHASE_BITS-1:0];
        return value;
    endfunction

    always @(posedge i_clk) begin
        logic signed [SAMPLE_BITS-1:0] due;
        if (!i_rst_n) begin
            pos          = '0;
            step_reg     = SPEED_STEP_RESET;
            loop_lo      = LOOP_START_RESET;
            loop_hi      = LOOP_FINISH_RESET;
            frames_valid = FRAME_COUNT_RESET;
            interp_due.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (t_cfg_reg'(i_cfg.reg_index))
                    REG_SPEED_STEP:  step_reg     = i_cfg.wr_data[STEP_BITS-1:0];
                    REG_LOOP_START:  loop_lo      = i_cfg.wr_data[LOOP_BITS-1:0];
                    REG_LOOP_FINISH: loop_hi      = i_cfg.wr_data[LOOP_BITS-1:0];
                    REG_FRAME_COUNT: frames_valid = i_cfg.wr_data[COUNT_BITS-1:0];
                    default: ;
                endcase
            end
            if (i_item.valid && i_item.ready) begin
                if (i_item.func == FUNC_WRITE) begin
                    pcm_mem[i_item.sample_addr[ADDR_BITS-1:0]] = i_item.sample_value;
                end else begin
                    interp_due.push_back(resample_tick());
                end
            end
            if (i_result.valid && i_result.ready) begin
                if (interp_due.size() == 0) begin
                    $display("%0t: interp_value %0d arrived with no tick outstanding",
                             $time, i_result.interp_value);
                    mismatches++;
                end else begin
                    due = interp_due.pop_front();
                    if (i_result.interp_value !== due) begin
                        $display("%0t: interp_value expected %0d, actual %0d",
                                 $time, due, i_result.interp_value);
                        mismatches++;
                    end
                end
            end
        end
        o_pending <= interp_due.size();
        o_errors  <= mismatches;
    end

endmodule

// File: sim/tb_looped_linear_resampler_unit.sv
// Testbench top: drives sample writes, playback ticks and register settings into the resampler.
module tb_looped_linear_resampler_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import llr_pkg::*;

    localparam int CLK_PERIOD    = 4;
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 32;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int CLIMB_TICKS   = 300;
    localparam int TOP_TICKS     = 4;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 120;
    localparam int FILL_FRAMES   = 256;

    localparam logic signed [SAMPLE_BITS-1:0] PCM_MIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
    localparam logic signed [SAMPLE_BITS-1:0] PCM_MAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};

    logic clk = 1'b0;
    logic rst_n;
    logic no_gaps = 1'b1;
    int   pending;
    int   errors;
    int   cycles = 0;

    llr_item_if   item_ch ();
    llr_result_if result_ch ();
    llr_cfg_if    cfg_ch ();

    looped_linear_resampler_unit i_dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_item   (item_ch),
        .o_result (result_ch),
        .i_cfg    (cfg_ch)
    );

    llr_playback_monitor u_playback_mon (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_item    (item_ch),
        .i_result  (result_ch),
        .i_cfg     (cfg_ch),
        .o_pending (pending),
        .o_errors  (errors)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb_looped_linear_resampler_unit: errors");
            $finish;
        end
    end

    function automatic int gap_draw();
        return no_gaps ? 0 : int'($urandom_range(0, 7));
    endfunction

    task automatic put_item(input t_func f, input logic [IN_ADDR_BITS-1:0] addr,
                            input logic signed [SAMPLE_BITS-1:0] value);
        int gap;
        gap = gap_draw();
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.func         <= f;
        item_ch.sample_addr  <= addr;
        item_ch.sample_value <= value;
        @(posedge clk);
        while (!item_ch.ready) @(posedge clk);
    endtask

    task automatic drain();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DATA_BITS-1:0] data);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.reg_index <= idx;
        cfg_ch.wr_data   <= data;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
    endtask

    task automatic set_regs(input logic [STEP_BITS-1:0] speed, input logic [LOOP_BITS-1:0] lo,
                            input logic [LOOP_BITS-1:0] hi, input logic [COUNT_BITS-1:0] frames);
        write_reg(REG_SPEED_STEP, CFG_DATA_BITS'(speed));
        write_reg(REG_LOOP_START, CFG_DATA_BITS'(lo));
        write_reg(REG_LOOP_FINISH, CFG_DATA_BITS'(hi));
        write_reg(REG_FRAME_COUNT, CFG_DATA_BITS'(frames));
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic random_regs();
        logic [STEP_BITS-1:0]  speed;
        logic [LOOP_BITS-1:0]  lo;
        logic [LOOP_BITS-1:0]  hi;
        logic [COUNT_BITS-1:0] frames;
        case ($urandom_range(0, 5))
            0: speed = '0;
            1: speed = '1;
            2, 3: speed = STEP_BITS'($urandom_range(0, 'h1FFFF));
            default: speed = STEP_BITS'($urandom);
        endcase
        case ($urandom_range(0, 3))
            0: begin
                hi = LOOP_BITS'($urandom_range(1, FILL_FRAMES + 2));
                lo = hi - LOOP_BITS'($urandom_range(1, (hi < 300) ? hi : 300));
            end
            1: begin
                lo = LOOP_BITS'($urandom);
                hi = LOOP_BITS'($urandom);
            end
            2: begin
                lo = $urandom_range(0, 1) ? '0 : '1;
                hi = ~lo;
            end
            default: begin
                hi = LOOP_BITS'($urandom_range(0, 65534));
                lo = LOOP_BITS'($urandom_range(hi + 1, 65535));
            end
        endcase
        case ($urandom_range(0, 3))
            0: frames = COUNT_BITS'(FILL_FRAMES);
            1: frames = '0;
            2: frames = COUNT_BITS'(hi) + COUNT_BITS'($urandom_range(0, 2));
            default: frames = COUNT_BITS'($urandom_range(0, FILL_FRAMES));
        endcase
        if (frames > COUNT_BITS'(FILL_FRAMES)) begin
            frames = COUNT_BITS'(FILL_FRAMES);
        end
        set_regs(speed, lo, hi, frames);
    endtask

    initial begin
        int ready_gap;
        result_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            ready_gap = gap_draw();
            if (ready_gap > 0) begin
                result_ch.ready <= 1'b0;
                repeat (ready_gap) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            @(posedge clk);
            while (!result_ch.valid) @(posedge clk);
        end
    end

    initial begin
        rst_n                <= 1'b0;
        item_ch.valid        <= 1'b0;
        item_ch.func         <= FUNC_WRITE;
        item_ch.sample_addr  <= '0;
        item_ch.sample_value <= '0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.reg_index     <= REG_SPEED_STEP;
        cfg_ch.wr_data       <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Only the lowest frames are loaded by this fill; random phases cap the frame count at them.
        for (int a = 0; a < FILL_FRAMES; a++) begin
            put_item(FUNC_WRITE, IN_ADDR_BITS'(a), SAMPLE_BITS'($urandom));
        end
        no_gaps = 1'b0;

        put_item(FUNC_WRITE, '0, PCM_MIN);
        put_item(FUNC_WRITE, IN_ADDR_BITS'(1), PCM_MAX);
        put_item(FUNC_WRITE, IN_ADDR_BITS'(2), PCM_MIN);
        put_item(FUNC_WRITE, '1, PCM_MAX);
        drain();
        set_regs(STEP_BITS'(1 << (FRAC_BITS - 1)), '0, LOOP_BITS'(3), COUNT_BITS'(STORE_DEPTH));
        repeat (8) put_item(FUNC_TICK, '0, '0);
        drain();
        set_regs('0, LOOP_BITS'(7), LOOP_BITS'(2), COUNT_BITS'(1));
        repeat (2) put_item(FUNC_TICK, '0, '0);
        drain();
        set_regs('0, LOOP_BITS'(7), LOOP_BITS'(2), COUNT_BITS'(2));
        repeat (2) put_item(FUNC_TICK, '0, '0);
        drain();
        set_regs(STEP_BITS'(1 << FRAC_BITS), LOOP_BITS'(4), LOOP_BITS'(4), '0);
        repeat (2) put_item(FUNC_TICK, '0, '0);
        drain();

        // Full speed without a loop drives the phase into saturation at the last frame.
        set_regs('1, '0, '0, COUNT_BITS'(FILL_FRAMES));
        repeat (CLIMB_TICKS) put_item(FUNC_TICK, '0, '0);
        drain();

        // A saturated phase reads the last frame of a full store and the empty frame above it.
        set_regs('1, '0, '0, COUNT_BITS'(STORE_DEPTH));
        repeat (TOP_TICKS) put_item(FUNC_TICK, '0, '0);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            drain();
            no_gaps = ($urandom_range(0, 3) == 0);
            random_regs();
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if ($urandom_range(0, 99) == 0) begin
                    drain();
                end
                if ($urandom_range(0, 9) < 3) begin
                    put_item(FUNC_WRITE, IN_ADDR_BITS'($urandom), SAMPLE_BITS'($urandom));
                end else begin
                    put_item(FUNC_TICK, IN_ADDR_BITS'($urandom), SAMPLE_BITS'($urandom));
                end
            end
        end
        drain();

        if (errors == 0) begin
            $display("tb_looped_linear_resampler_unit: clean");
        end else begin
            $display("tb_looped_linear_resampler_unit: errors");
        end
        $finish;
    end

endmodule
